FILE: design/nbodc_pkg.sv
// Package for the NAND block order-dependency checker: constants, types and helpers.
`timescale 1ns / 1ps

package nbodc_pkg;

  localparam int CHANNELS        = 8;
  localparam int WAYS            = 8;
  localparam int BLOCKS_PER_DIE  = 1024;
  localparam int PAGES_PER_BLOCK = 256;

  localparam int ENTRY_COUNT = CHANNELS * WAYS * BLOCKS_PER_DIE;
  localparam int ENTRY_W     = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;

  typedef logic [ENTRY_W-1:0] entry_idx_t;

  typedef enum logic [1:0] {
    MODE_SELECT  = 2'd0,
    MODE_RELEASE = 2'd1,
    MODE_RECORD  = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_ERASE = 2'd2
  } kind_e;

  typedef struct packed {
    logic [1:0] mode;
    logic [1:0] req_kind;
    logic [2:0] channel;
    logic [2:0] way;
    logic [9:0] block_index;
    logic [7:0] page_index;
    logic [8:0] programmed_pages;
  } req_t;

  typedef struct packed {
    logic       pass;
    logic       erase_sync_needed;
    logic [8:0] permitted_page;
  } rsp_t;

  typedef struct packed {
    logic [8:0]  next_program_page;
    logic [15:0] waiting_read_count;
    logic        erase_pending;
  } entry_t;

  // Result of one read-modify-write step
  typedef struct packed {
    logic   we;
    entry_t entry;
    rsp_t   rsp;
  } upd_t;

  function automatic logic addr_in_range(req_t req);
    return (int'(req.channel) < CHANNELS) && (int'(req.way) < WAYS) &&
           (int'(req.block_index) < BLOCKS_PER_DIE);
  endfunction

  function automatic entry_idx_t entry_index(req_t req);
    int sum;
    sum = (int'(req.channel) * WAYS + int'(req.way)) * BLOCKS_PER_DIE +
          int'(req.block_index);
    return sum[ENTRY_W-1:0];
  endfunction

endpackage

FILE: design/nbodc_update.sv
// Record update logic: checks one request against its block record.
`timescale 1ns / 1ps

module nbodc_update import nbodc_pkg::*; (
  input  req_t   req_i,
  input  entry_t entry_i,
  output upd_t   upd_o
);

  entry_t ent;
  logic   pass;
  logic   sync;
  logic   read_ok;
  logic   cnt_full;
  logic   cnt_zero;

  always_comb begin
    ent      = entry_i;
    pass     = 1'b0;
    sync     = 1'b0;
    read_ok  = {1'b0, req_i.page_index} < entry_i.next_program_page;
    cnt_full = (entry_i.waiting_read_count == '1);
    cnt_zero = (entry_i.waiting_read_count == '0);

    case (req_i.mode)
      MODE_SELECT, MODE_RELEASE: begin
        case (req_i.req_kind)
          KIND_READ: begin
            if (req_i.mode == MODE_SELECT) begin
              sync = entry_i.erase_pending;
              if (read_ok) begin
                pass = 1'b1;
              end else if (!cnt_full) begin
                ent.waiting_read_count = entry_i.waiting_read_count + 16'd1;
              end
            end else if (read_ok) begin
              pass = 1'b1;
              if (!cnt_zero) begin
                ent.waiting_read_count = entry_i.waiting_read_count - 16'd1;
              end
            end
          end
          KIND_WRITE: begin
            if ((int'(req_i.page_index) < PAGES_PER_BLOCK) &&
                ({1'b0, req_i.page_index} == entry_i.next_program_page)) begin
              ent.next_program_page = entry_i.next_program_page + 9'd1;
              pass = 1'b1;
            end
          end
          KIND_ERASE: begin
            if ((entry_i.next_program_page == req_i.programmed_pages) && cnt_zero) begin
              ent.next_program_page = '0;
              ent.erase_pending     = 1'b0;
              pass = 1'b1;
            end else if (req_i.mode == MODE_SELECT) begin
              ent.erase_pending = 1'b1;
            end
          end
          default: ;
        endcase
      end
      MODE_RECORD: begin
        case (req_i.req_kind)
          KIND_READ: begin
            sync = entry_i.erase_pending;
            if (!cnt_full) begin
              ent.waiting_read_count = entry_i.waiting_read_count + 16'd1;
            end
          end
          KIND_ERASE: ent.erase_pending = 1'b1;
          default: ;
        endcase
      end
      default: ;
    endcase

    // Drop requests that address no block
    if (addr_in_range(req_i)) begin
      upd_o.we                    = 1'b1;
      upd_o.entry                 = ent;
      upd_o.rsp.pass              = pass;
      upd_o.rsp.erase_sync_needed = sync;
      upd_o.rsp.permitted_page    = ent.next_program_page;
    end else begin
      upd_o.we    = 1'b0;
      upd_o.entry = entry_i;
      upd_o.rsp   = '0;
    end
  end

endmodule

FILE: design/nand_block_order_dependency_check_core.sv
// Top level of the NAND block order-dependency checker.
`timescale 1ns / 1ps
//
// Checks flash requests against a per-block record (next programmable page,
// waiting-read count, erase-pending flag) held in one on-chip memory of
// CHANNELS*WAYS*BLOCKS_PER_DIE entries, addressed by channel, way and block.
// Input channel: in_valid_i / in_stall_o with the request in in_req_i.
// Output channel: out_valid_o / out_stall_i with the answer in out_rsp_o.
// A transaction is taken at a clock edge with valid high and stall low.
// The memory is read into the update stage when a request is accepted;
// update and write-back happen as it moves on to the output register.
// Throughput: one request per cycle while out_stall_i is low, set by the
// single read-modify-write port of the record memory; back-to-back hits on
// one block are forwarded. After reset the memory is cleared one entry per
// cycle, all ENTRY_COUNT entries (65536 by default), while in_stall_o stays
// high. When the receiver stalls, the answer holds in the output register,
// one more request may sit in the update stage, and then in_stall_o rises.

module nand_block_order_dependency_check_core import nbodc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  req_t in_req_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output rsp_t out_rsp_o
);

  entry_t     mem [ENTRY_COUNT];

  logic       clearing_q;
  entry_idx_t clr_idx_q;

  logic       s1_valid_q;
  req_t       s1_req_q;
  entry_idx_t s1_idx_q;
  entry_t     rd_data_q;
  logic       fwd_q;
  entry_t     fwd_entry_q;

  logic       out_valid_q;
  rsp_t       out_rsp_q;

  entry_idx_t in_idx;
  logic       in_acc;
  logic       adv;
  entry_t     cur_entry;
  upd_t       upd;
  logic       fwd_d;

  logic       mem_we;
  entry_idx_t mem_waddr;
  entry_t     mem_wdata;

  assign in_idx    = entry_index(in_req_i);
  assign adv       = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = clearing_q || (s1_valid_q && !adv);
  assign in_acc    = in_valid_i && !in_stall_o;
  assign cur_entry = fwd_q ? fwd_entry_q : rd_data_q;
  assign fwd_d     = adv && upd.we && (s1_idx_q == in_idx);

  nbodc_update u_update (
    .req_i   (s1_req_q),
    .entry_i (cur_entry),
    .upd_o   (upd)
  );

  always_comb begin
    if (clearing_q) begin
      mem_we    = 1'b1;
      mem_waddr = clr_idx_q;
      mem_wdata = '0;
    end else begin
      mem_we    = adv && upd.we;
      mem_waddr = s1_idx_q;
      mem_wdata = upd.entry;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (in_acc) begin
      rd_data_q <= mem[in_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_idx_q  <= '0;
    end else if (clearing_q) begin
      if (int'(clr_idx_q) == ENTRY_COUNT - 1) begin
        clearing_q <= 1'b0;
      end else begin
        clr_idx_q <= clr_idx_q + entry_idx_t'(1);
      end
    end
  end

  // Update stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_req_q    <= in_req_i;
      s1_idx_q    <= in_idx;
      fwd_q       <= fwd_d;
      fwd_entry_q <= upd.entry;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_rsp_q <= upd.rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  a_clear_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing_q |-> (!s1_valid_q && !out_valid_q))
    else $error("pipeline busy during memory clear");

  a_fwd_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && adv && upd.we && (s1_idx_q == in_idx)) |=> fwd_q)
    else $error("same-entry write not forwarded");

  a_range_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !addr_in_range(s1_req_q)) |-> (!upd.we && upd.rsp == '0))
    else $error("out-of-range request changed state");

  a_write_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && upd.rsp.pass && s1_req_q.req_kind == KIND_WRITE)
      |-> (upd.entry.next_program_page == cur_entry.next_program_page + 9'd1))
    else $error("passed write did not advance page");

endmodule
